FILE: design/brti_pkg.sv
package brti_pkg;

   // field widths
   localparam int COORD_W   = 24;
   localparam int HEAD_W    = 17;
   localparam int STEP_W    = 20;
   localparam int JIT_W     = 16;
   localparam int SYM_W     = 8;
   localparam int ANGLE_W   = 15;
   localparam int SINE_W    = 15;
   localparam int VEC_W     = 22;
   localparam int CSR_W     = 24;
   localparam int CSR_IDX_W = 3;
   localparam int SETTLE_W  = 3;

   localparam int STACK_DEPTH_DEF = 32;

   // angles in 1/256 degree
   localparam logic [HEAD_W-1:0] QUARTER_TURN       = 17'd23040;
   localparam logic [HEAD_W-1:0] HALF_TURN          = 17'd46080;
   localparam logic [HEAD_W-1:0] THREE_QUARTER_TURN = 17'd69120;
   localparam logic [HEAD_W-1:0] FULL_TURN          = 17'd92160;

   // cycles from a heading change until the move vector follows it
   localparam logic [SETTLE_W-1:0] MOVE_LATENCY = 3'd4;

   // symbol codes
   localparam logic [SYM_W-1:0] SYM_F     = 8'h46;
   localparam logic [SYM_W-1:0] SYM_G     = 8'h47;
   localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
   localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;
   localparam logic [SYM_W-1:0] SYM_PUSH  = 8'h5B;
   localparam logic [SYM_W-1:0] SYM_POP   = 8'h5D;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TURN_ANGLE    = 3'd0,
      CSR_START_HEADING = 3'd1,
      CSR_STEP_LENGTH   = 3'd2,
      CSR_START_X       = 3'd3,
      CSR_START_Y       = 3'd4,
      CSR_USE_JITTER    = 3'd5
   } csr_index_type;

   // register reset values
   localparam logic [HEAD_W-1:0]  TURN_ANGLE_RST    = 17'd6400;
   localparam logic [HEAD_W-1:0]  START_HEADING_RST = 17'd69120;
   localparam logic [STEP_W-1:0]  STEP_LENGTH_RST   = 20'd2560;

   typedef struct packed {
      logic signed [VEC_W-1:0] dx;
      logic signed [VEC_W-1:0] dy;
   } move_vec_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic [HEAD_W-1:0]         h;
   } stack_entry_type;

   // sin(k degrees) in unsigned Q0.15, k = 0..90
   localparam logic [SINE_W-1:0] SINE_DEG [0:90] = '{
      15'd0,     15'd572,   15'd1144,  15'd1715,  15'd2286,  15'd2856,  15'd3425,
      15'd3993,  15'd4560,  15'd5126,  15'd5690,  15'd6252,  15'd6813,  15'd7371,
      15'd7927,  15'd8481,  15'd9032,  15'd9580,  15'd10126, 15'd10668, 15'd11207,
      15'd11743, 15'd12275, 15'd12803, 15'd13328, 15'd13848, 15'd14365, 15'd14876,
      15'd15384, 15'd15886, 15'd16384, 15'd16877, 15'd17364, 15'd17847, 15'd18324,
      15'd18795, 15'd19261, 15'd19720, 15'd20174, 15'd20622, 15'd21063, 15'd21498,
      15'd21926, 15'd22348, 15'd22763, 15'd23170, 15'd23571, 15'd23965, 15'd24351,
      15'd24730, 15'd25102, 15'd25466, 15'd25822, 15'd26170, 15'd26510, 15'd26842,
      15'd27166, 15'd27482, 15'd27789, 15'd28088, 15'd28378, 15'd28660, 15'd28932,
      15'd29197, 15'd29452, 15'd29698, 15'd29935, 15'd30163, 15'd30382, 15'd30592,
      15'd30792, 15'd30983, 15'd31164, 15'd31336, 15'd31499, 15'd31651, 15'd31795,
      15'd31928, 15'd32052, 15'd32166, 15'd32270, 15'd32365, 15'd32449, 15'd32524,
      15'd32588, 15'd32643, 15'd32688, 15'd32723, 15'd32748, 15'd32763, 15'd32767
   };

endpackage

FILE: design/brti_move_vector.sv
module brti_move_vector
   import brti_pkg::*;
(
   input  logic              clock,
   input  logic [HEAD_W-1:0] heading,
   input  logic [STEP_W-1:0] step_length,
   output move_vec_type      move_vec
);

   typedef struct packed {
      logic               neg;
      logic [ANGLE_W-1:0] ang;
   } fold_type;

   // fold a heading onto the first quadrant, keep the sign of the sine
   function automatic fold_type fold(input logic [HEAD_W-1:0] h);
      fold_type r;
      if (h < QUARTER_TURN) begin
         r.neg = 1'b0;
         r.ang = ANGLE_W'(h);
      end else if (h < HALF_TURN) begin
         r.neg = 1'b0;
         r.ang = ANGLE_W'(HALF_TURN - h);
      end else if (h < THREE_QUARTER_TURN) begin
         r.neg = 1'b1;
         r.ang = ANGLE_W'(h - HALF_TURN);
      end else begin
         r.neg = 1'b1;
         r.ang = ANGLE_W'(FULL_TURN - h);
      end
      return r;
   endfunction

   // table lookup with linear interpolation over the low 8 bits
   function automatic logic [SINE_W-1:0] quarter_sine(input logic [ANGLE_W-1:0] a);
      logic [6:0]        k;
      logic [6:0]        kn;
      logic [7:0]        f;
      logic [9:0]        diff;
      logic [18:0]       part;
      k    = (a[14:8] >= 7'd90) ? 7'd90 : a[14:8];
      kn   = (k == 7'd90) ? k : k + 7'd1;
      f    = a[7:0];
      diff = 10'(SINE_DEG[kn] - SINE_DEG[k]);
      part = 19'(diff * f) + 19'd128;
      return SINE_DEG[k] + SINE_W'(part >> 8);
   endfunction

   logic [HEAD_W-1:0]          cos_head;
   fold_type                   s1_sin_ff, s1_cos_ff;
   logic [SINE_W-1:0]          s2_sin_ff, s2_cos_ff;
   logic                       s2_sin_neg_ff, s2_cos_neg_ff;
   logic [SINE_W+STEP_W-1:0]   s3_sin_ff, s3_cos_ff;
   logic                       s3_sin_neg_ff, s3_cos_neg_ff;
   logic [SINE_W+STEP_W:0]     rnd_sin, rnd_cos;
   logic [VEC_W-1:0]           mag_sin, mag_cos;
   move_vec_type               vec_in, vec_ff;

   // cosine is the sine a quarter turn on
   assign cos_head = (heading >= THREE_QUARTER_TURN) ? heading - THREE_QUARTER_TURN
                                                     : heading + QUARTER_TURN;

   // fold, look up, scale by the step, then register the rounded, signed vector
   always_ff @(posedge clock) begin
      s1_sin_ff     <= fold(heading);
      s1_cos_ff     <= fold(cos_head);
      s2_sin_ff     <= quarter_sine(s1_sin_ff.ang);
      s2_cos_ff     <= quarter_sine(s1_cos_ff.ang);
      s2_sin_neg_ff <= s1_sin_ff.neg;
      s2_cos_neg_ff <= s1_cos_ff.neg;
      s3_sin_ff     <= s2_sin_ff * step_length;
      s3_cos_ff     <= s2_cos_ff * step_length;
      s3_sin_neg_ff <= s2_sin_neg_ff;
      s3_cos_neg_ff <= s2_cos_neg_ff;
      vec_ff        <= vec_in;
   end

   // round the magnitude half up, then apply the sign
   always_comb begin
      rnd_sin   = {1'b0, s3_sin_ff} + (SINE_W+STEP_W+1)'(16384);
      rnd_cos   = {1'b0, s3_cos_ff} + (SINE_W+STEP_W+1)'(16384);
      mag_sin   = {1'b0, rnd_sin[35:15]};
      mag_cos   = {1'b0, rnd_cos[35:15]};
      vec_in.dy = s3_sin_neg_ff ? -$signed(mag_sin) : $signed(mag_sin);
      vec_in.dx = s3_cos_neg_ff ? -$signed(mag_cos) : $signed(mag_cos);
   end

   assign move_vec = vec_ff;

endmodule

FILE: design/bracketed_turtle_interpreter_unit.sv
// Turtle interpreter for bracketed L-system strings.
// req channel: one symbol per item. tdata = {angle_jitter, symbol}, tuser = first.
// A set first flag restarts the turtle (start position, start heading, empty
// stack) before the symbol is handled.
// rsp channel: one item per F symbol, tdata = {y_to, x_to, y_from, x_from}.
// csr port: write enable, register index and data; write only while idle.
// Items enter an input register and are handled from there. Turns, pushes,
// pops and unknown symbols are handled back to back. F and G move by a
// precomputed step vector; that vector comes from a four-stage pipeline
// (fold, sine table lookup, multiply by step length, round), so a move that
// follows a heading change (turn, pop, restart) or a step_length write waits
// until the vector has caught up, then one move per cycle while no F waits on
// the output register. An F result passes the input register, then the output
// register. The output register holds while rsp_tready is low and the input
// side keeps taking items that produce no result; an F behind a full output
// register waits. Reset clears the registers to their defaults, places the
// turtle at the start, empties the stack and makes moves wait until the vector
// has settled. The stack memory is never cleared.
module bracketed_turtle_interpreter_unit
   import brti_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [23:0]          req_tdata,   // symbol [7:0], angle_jitter [23:8]
   input  logic                 req_tuser,   // first
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [95:0]          rsp_tdata,   // x_from, y_from, x_to, y_to
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   // configuration
   logic [HEAD_W-1:0]          turn_ff, start_head_ff;
   logic [STEP_W-1:0]          step_ff;
   logic signed [COORD_W-1:0]  start_x_ff, start_y_ff;
   logic                       use_jit_ff;
   logic [HEAD_W-1:0]          csr_angle;

   // input register
   logic                       in_valid_ff, in_valid_in;
   logic [SYM_W-1:0]           in_sym_ff;
   logic                       in_first_ff;
   logic signed [JIT_W-1:0]    in_jit_ff;

   // turtle state
   logic signed [COORD_W-1:0]  x_ff, x_in, y_ff, y_in;
   logic [HEAD_W-1:0]          heading_ff, heading_in;
   logic [DEPTH_W-1:0]         depth_ff, depth_in;
   logic [SETTLE_W-1:0]        settle_ff, settle_in;

   // output register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [95:0]                rsp_data_ff;

   // stack
   stack_entry_type            stack_mem [STACK_DEPTH];
   stack_entry_type            top_ff, push_entry;
   logic                       stk_we;
   logic [ADDR_W-1:0]          wr_addr, rd_addr;
   logic [DEPTH_W-1:0]         rd_full;

   move_vec_type               move_vec;
   logic                       is_move, out_free, restart_go, exec, out_load, accept;
   logic signed [COORD_W-1:0]  nx, ny;
   logic signed [18:0]         delta, jit_ext;
   logic signed [19:0]         turn_sum;
   logic [HEAD_W-1:0]          turned;

   function automatic logic signed [COORD_W-1:0] step_sat(
      input logic signed [COORD_W-1:0] pos,
      input logic signed [VEC_W-1:0]   d
   );
      logic signed [COORD_W:0] sum;
      sum = {pos[COORD_W-1], pos} + {{(COORD_W+1-VEC_W){d[VEC_W-1]}}, d};
      if (sum > $signed({2'b00, {(COORD_W-1){1'b1}}})) begin
         return {1'b0, {(COORD_W-1){1'b1}}};
      end else if (sum < $signed({2'b11, {(COORD_W-1){1'b0}}})) begin
         return {1'b1, {(COORD_W-1){1'b0}}};
      end
      return sum[COORD_W-1:0];
   endfunction

   brti_move_vector u_move_vector (
      .clock       (clock),
      .heading     (heading_ff),
      .step_length (step_ff),
      .move_vec    (move_vec)
   );

   // handshake and issue conditions
   assign is_move    = in_sym_ff inside {SYM_F, SYM_G};
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign restart_go = in_valid_ff && in_first_ff;
   assign exec       = in_valid_ff && !in_first_ff &&
                       (!is_move || (settle_ff == '0 && (in_sym_ff != SYM_F || out_free)));
   assign out_load   = exec && in_sym_ff == SYM_F;
   assign req_tready = !in_valid_ff || exec;
   assign accept     = req_tvalid && req_tready;

   // moved position and turned heading
   assign nx      = step_sat(x_ff, move_vec.dx);
   assign ny      = step_sat(y_ff, move_vec.dy);
   assign jit_ext = use_jit_ff ? 19'(in_jit_ff) : '0;
   assign delta   = $signed({2'b00, turn_ff}) + jit_ext;

   always_comb begin
      turn_sum = (in_sym_ff == SYM_PLUS) ? $signed({3'b000, heading_ff}) + 20'(delta)
                                         : $signed({3'b000, heading_ff}) - 20'(delta);
      // fold back into one full turn
      if (turn_sum < -$signed({3'b000, FULL_TURN})) begin
         turned = HEAD_W'(turn_sum + $signed({2'b00, FULL_TURN, 1'b0}));
      end else if (turn_sum < 0) begin
         turned = HEAD_W'(turn_sum + $signed({3'b000, FULL_TURN}));
      end else if (turn_sum >= $signed({2'b00, FULL_TURN, 1'b0})) begin
         turned = HEAD_W'(turn_sum - $signed({2'b00, FULL_TURN, 1'b0}));
      end else if (turn_sum >= $signed({3'b000, FULL_TURN})) begin
         turned = HEAD_W'(turn_sum - $signed({3'b000, FULL_TURN}));
      end else begin
         turned = HEAD_W'(turn_sum);
      end
   end

   // next turtle state
   always_comb begin
      x_in       = x_ff;
      y_in       = y_ff;
      heading_in = heading_ff;
      depth_in   = depth_ff;
      stk_we     = 1'b0;
      settle_in  = (settle_ff == '0) ? '0 : settle_ff - 1'b1;
      if (restart_go) begin
         x_in       = start_x_ff;
         y_in       = start_y_ff;
         heading_in = start_head_ff;
         depth_in   = '0;
         settle_in  = MOVE_LATENCY;
      end else if (exec) begin
         case (in_sym_ff)
            SYM_F, SYM_G: begin
               x_in = nx;
               y_in = ny;
            end
            SYM_PLUS, SYM_MINUS: begin
               heading_in = turned;
               settle_in  = MOVE_LATENCY;
            end
            SYM_PUSH: begin
               if (depth_ff < DEPTH_W'(STACK_DEPTH)) begin
                  stk_we   = 1'b1;
                  depth_in = depth_ff + 1'b1;
               end
            end
            SYM_POP: begin
               if (depth_ff != '0) begin
                  depth_in   = depth_ff - 1'b1;
                  x_in       = top_ff.x;
                  y_in       = top_ff.y;
                  heading_in = top_ff.h;
                  settle_in  = MOVE_LATENCY;
               end
            end
            default: begin
            end
         endcase
      end
      if (csr_we && csr_index == CSR_STEP_LENGTH) begin
         settle_in = MOVE_LATENCY;
      end
   end

   // input and output register control
   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (exec) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control and turtle registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         x_ff         <= '0;
         y_ff         <= '0;
         heading_ff   <= START_HEADING_RST;
         depth_ff     <= '0;
         settle_ff    <= MOVE_LATENCY;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         heading_ff   <= heading_in;
         depth_ff     <= depth_in;
         settle_ff    <= settle_in;
      end
   end

   // hold the item and the result
   always_ff @(posedge clock) begin
      if (accept) begin
         in_sym_ff   <= req_tdata[7:0];
         in_jit_ff   <= req_tdata[23:8];
         in_first_ff <= req_tuser;
      end else if (restart_go) begin
         in_first_ff <= 1'b0;
      end
      if (out_load) begin
         rsp_data_ff <= {ny, nx, y_ff, x_ff};
      end
   end

   // configuration writes, angles reduced to one full turn on entry
   assign csr_angle = (csr_wdata[16:0] >= FULL_TURN) ? csr_wdata[16:0] - FULL_TURN
                                                     : csr_wdata[16:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         turn_ff       <= TURN_ANGLE_RST;
         start_head_ff <= START_HEADING_RST;
         step_ff       <= STEP_LENGTH_RST;
         start_x_ff    <= '0;
         start_y_ff    <= '0;
         use_jit_ff    <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TURN_ANGLE:    turn_ff       <= csr_angle;
            CSR_START_HEADING: start_head_ff <= csr_angle;
            CSR_STEP_LENGTH:   step_ff       <= csr_wdata[STEP_W-1:0];
            CSR_START_X:       start_x_ff    <= csr_wdata[COORD_W-1:0];
            CSR_START_Y:       start_y_ff    <= csr_wdata[COORD_W-1:0];
            CSR_USE_JITTER:    use_jit_ff    <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // stack memory; the read port holds the entry below the next depth whenever that depth is nonzero
   assign push_entry = '{x: x_ff, y: y_ff, h: heading_ff};
   assign wr_addr    = depth_ff[ADDR_W-1:0];
   assign rd_full    = (depth_in == '0) ? '0 : depth_in - 1'b1;
   assign rd_addr    = rd_full[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stack_mem[wr_addr] <= push_entry;
      end
      if (stk_we && wr_addr == rd_addr) begin
         top_ff <= push_entry;
      end else begin
         top_ff <= stack_mem[rd_addr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DEPTH_W'(STACK_DEPTH))
      else $error("stack depth beyond capacity");

   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      heading_ff < FULL_TURN)
      else $error("heading outside one full turn");

   a_heading_settle: assert property (@(posedge clock) disable iff (reset)
      heading_ff != $past(heading_ff) |-> settle_ff != '0)
      else $error("heading changed without waiting for the move vector");

   a_move_settled: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_tvalid && settle_ff == '0)
      else $error("segment issued before the move vector settled");
`endif

endmodule

FILE: test/tb_bracketed_turtle_interpreter_unit.sv
module tb_bracketed_turtle_interpreter_unit;
   import brti_pkg::*;

   localparam int     FULL         = int'(FULL_TURN);
   localparam int     QUARTER      = int'(QUARTER_TURN);
   localparam longint COORD_HI     = 64'sd8388607;
   localparam longint COORD_LO     = -64'sd8388608;
   localparam int     QUIET_CYCLES = 4 * int'(MOVE_LATENCY) + 4;
   localparam int     LONG_HOLD    = 200;
   localparam int     STALL_LIMIT  = 2000;
   localparam int     MAX_REPORTS  = 10;

   // index with no register behind it
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 3'd6;

   // result item as it sits on rsp_tdata, x_from in the lowest bits
   typedef struct packed {
      logic signed [COORD_W-1:0] y_to;
      logic signed [COORD_W-1:0] x_to;
      logic signed [COORD_W-1:0] y_from;
      logic signed [COORD_W-1:0] x_from;
   } segment_type;

   // Turtle mirror: walks every accepted symbol and keeps the segments it
   // should draw, oldest first.
   class segment_ledger;
      logic [HEAD_W-1:0]         turn_angle;
      logic [HEAD_W-1:0]         start_heading;
      logic [STEP_W-1:0]         step_length;
      logic signed [COORD_W-1:0] start_x;
      logic signed [COORD_W-1:0] start_y;
      bit                        use_jitter;

      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      int                        heading;
      logic signed [COORD_W-1:0] saved_x [STACK_DEPTH_DEF];
      logic signed [COORD_W-1:0] saved_y [STACK_DEPTH_DEF];
      int                        saved_heading [STACK_DEPTH_DEF];
      int                        depth;

      segment_type               segments_due [$];
      int unsigned               fault_count;

      function void restart();
         pos_x   = start_x;
         pos_y   = start_y;
         heading = int'(start_heading) % FULL;
         depth   = 0;
      endfunction

      function void restore_defaults();
         turn_angle    = TURN_ANGLE_RST;
         start_heading = START_HEADING_RST;
         step_length   = STEP_LENGTH_RST;
         start_x       = '0;
         start_y       = '0;
         use_jitter    = 1'b0;
         fault_count   = 0;
         segments_due.delete();
         restart();
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] value);
         case (idx)
            CSR_TURN_ANGLE:    turn_angle    = value[HEAD_W-1:0];
            CSR_START_HEADING: start_heading = value[HEAD_W-1:0];
            CSR_STEP_LENGTH:   step_length   = value[STEP_W-1:0];
            CSR_START_X:       start_x       = value;
            CSR_START_Y:       start_y       = value;
            CSR_USE_JITTER:    use_jitter    = value[0];
            default: ;
         endcase
      endfunction

      // sine over 0..90 degrees, linear between whole degrees
      function int quarter_sine(int a);
         int k;
         int f;
         k = a >> 8;
         f = a & 255;
         if (k >= 90) return 32767;
         return int'(SINE_DEG[k])
            + (((int'(SINE_DEG[k+1]) - int'(SINE_DEG[k])) * f + 128) >> 8);
      endfunction

      function int sine_of(int h);
         int q;
         int r;
         h = h % FULL;
         q = h / QUARTER;
         r = h % QUARTER;
         case (q)
            0:       return quarter_sine(r);
            1:       return quarter_sine(QUARTER - r);
            2:       return -quarter_sine(r);
            default: return -quarter_sine(QUARTER - r);
         endcase
      endfunction

      // scale by step length, round magnitude half up, saturate
      function logic signed [COORD_W-1:0] advance(logic signed [COORD_W-1:0] pos, int trig);
         longint mag;
         longint sum;
         mag = (trig < 0) ? -longint'(trig) : longint'(trig);
         mag = (mag * longint'(step_length) + 16384) >> 15;
         sum = longint'(pos) + ((trig < 0) ? -mag : mag);
         if (sum > COORD_HI) sum = COORD_HI;
         if (sum < COORD_LO) sum = COORD_LO;
         return sum[COORD_W-1:0];
      endfunction

      function void take_symbol(logic [SYM_W-1:0] sym, bit first,
                                logic signed [JIT_W-1:0] jitter);
         int                        delta;
         int                        turned;
         logic signed [COORD_W-1:0] nx;
         logic signed [COORD_W-1:0] ny;
         segment_type               seg;
         if (first) restart();
         delta = int'(turn_angle) % FULL;
         if (use_jitter) delta += jitter;
         case (sym)
            SYM_F, SYM_G: begin
               nx = advance(pos_x, sine_of(heading + QUARTER));
               ny = advance(pos_y, sine_of(heading));
               if (sym == SYM_F) begin
                  seg.x_from = pos_x;
                  seg.y_from = pos_y;
                  seg.x_to   = nx;
                  seg.y_to   = ny;
                  segments_due.push_back(seg);
               end
               pos_x = nx;
               pos_y = ny;
            end
            SYM_PLUS, SYM_MINUS: begin
               turned = heading + ((sym == SYM_PLUS) ? delta : -delta);
               turned = turned % FULL;
               if (turned < 0) turned += FULL;
               heading = turned;
            end
            // push is dropped once the stack is full
            SYM_PUSH: begin
               if (depth < STACK_DEPTH_DEF) begin
                  saved_x[depth]       = pos_x;
                  saved_y[depth]       = pos_y;
                  saved_heading[depth] = heading;
                  depth++;
               end
            end
            // pop is dropped on an empty stack
            SYM_POP: begin
               if (depth > 0) begin
                  depth--;
                  pos_x   = saved_x[depth];
                  pos_y   = saved_y[depth];
                  heading = saved_heading[depth];
               end
            end
            default: ;
         endcase
      endfunction

      function void note_fault(string msg);
         fault_count++;
         if (fault_count <= MAX_REPORTS) $display("mismatch: %s", msg);
      endfunction

      function void compare_coord(string field, logic signed [COORD_W-1:0] want,
                                  logic signed [COORD_W-1:0] got);
         if (got !== want)
            note_fault($sformatf("%s expected %0d, got %0d", field, want, got));
      endfunction

      function void match_segment(segment_type got);
         segment_type want;
         if (segments_due.size() == 0) begin
            note_fault($sformatf("segment (%0d,%0d)->(%0d,%0d) with none due",
                                 got.x_from, got.y_from, got.x_to, got.y_to));
            return;
         end
         want = segments_due.pop_front();
         compare_coord("x_from", want.x_from, got.x_from);
         compare_coord("y_from", want.y_from, got.y_from);
         compare_coord("x_to",   want.x_to,   got.x_to);
         compare_coord("y_to",   want.y_to,   got.y_to);
      endfunction

      function int pending();
         return segments_due.size();
      endfunction
   endclass

   logic                 clock;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [23:0]          req_tdata  = '0;   // symbol [7:0], angle_jitter [23:8]
   logic                 req_tuser  = 1'b0; // first
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [95:0]          rsp_tdata;         // x_from, y_from, x_to, y_to
   logic                 csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [CSR_W-1:0]     csr_wdata  = '0;

   int unsigned   send_idle_pct = 35;
   int unsigned   recv_idle_pct = 50;
   logic          hold_rsp      = 1'b0;
   int unsigned   held_cycles   = 0;
   segment_ledger ledger;

   bracketed_turtle_interpreter_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver: random stalls, plus one long hold-off when asked
   initial begin
      forever begin
         @(posedge clock);
         if (hold_rsp && held_cycles < LONG_HOLD) begin
            held_cycles++;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // note accepted symbols and check accepted segments
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            ledger.take_symbol(req_tdata[SYM_W-1:0], req_tuser, req_tdata[23:8]);
         if (rsp_tvalid && rsp_tready)
            ledger.match_segment(rsp_tdata);
      end
   end

   // give up when nothing moves on either channel for too long
   initial begin
      int unsigned stall_cycles;
      stall_cycles = 0;
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            stall_cycles = 0;
         else
            stall_cycles++;
      end
      $display("** bracketed_turtle_interpreter_unit: FAILED **");
      $finish;
   end

   task automatic send_symbol(input logic [SYM_W-1:0] sym, input bit first,
                              input logic [JIT_W-1:0] jitter);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {jitter, sym};
      req_tuser  <= first;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      ledger.write_reg(idx, value);
   endtask

   task automatic load_settings(input logic [CSR_W-1:0] turn, head, step, sx, sy, jit);
      write_csr(CSR_SPARE, '1);
      write_csr(CSR_TURN_ANGLE, turn);
      write_csr(CSR_START_HEADING, head);
      write_csr(CSR_STEP_LENGTH, step);
      write_csr(CSR_START_X, sx);
      write_csr(CSR_START_Y, sy);
      write_csr(CSR_USE_JITTER, jit);
      csr_we <= 1'b0;
   endtask

   // stop offering, wait for every segment, then let the move pipeline settle
   task automatic drain();
      req_tvalid <= 1'b0;
      while (ledger.pending() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   function automatic logic [JIT_W-1:0] random_jitter();
      if ($urandom_range(9) == 0) return JIT_W'($urandom);
      return JIT_W'($urandom_range(2 * QUARTER) - QUARTER);
   endfunction

   // extremes, every symbol, a pop on an empty stack, ignored codes
   task automatic run_directed();
      send_symbol(SYM_F,     1'b1, '0);
      send_symbol(SYM_F,     1'b0, '0);
      send_symbol(SYM_PLUS,  1'b0, 16'h7FFF);
      send_symbol(SYM_F,     1'b0, '0);
      send_symbol(SYM_MINUS, 1'b0, 16'h8000);
      send_symbol(SYM_G,     1'b0, '1);
      send_symbol(SYM_F,     1'b0, '0);
      send_symbol(SYM_PUSH,  1'b0, '0);
      send_symbol(SYM_PLUS,  1'b0, '0);
      send_symbol(SYM_F,     1'b0, '0);
      send_symbol(SYM_POP,   1'b0, '0);
      send_symbol(SYM_F,     1'b0, '0);
      send_symbol(SYM_POP,   1'b1, '0);
      send_symbol(SYM_F,     1'b0, '0);
      send_symbol(8'h00,     1'b0, '0);
      send_symbol(8'hFF,     1'b0, '1);
      send_symbol(8'h66,     1'b0, '0);
      send_symbol(SYM_F,     1'b0, '0);
   endtask

   // nest past the stack depth, then unwind past empty
   task automatic run_deep_nest();
      int i;
      send_symbol(SYM_F, 1'b1, '0);
      for (i = 0; i < STACK_DEPTH_DEF + 2; i++) begin
         send_symbol(SYM_PUSH, 1'b0, '0);
         send_symbol((i % 2 == 0) ? SYM_G : SYM_PLUS, 1'b0, random_jitter());
      end
      send_symbol(SYM_F, 1'b0, '0);
      for (i = 0; i < STACK_DEPTH_DEF + 3; i++) begin
         send_symbol(SYM_POP, 1'b0, '0);
         send_symbol(SYM_F,   1'b0, '0);
      end
   endtask

   // strings that usually open with a restart and mostly keep brackets balanced;
   // a few stray pops, mid-string restarts and unknown codes mixed in
   task automatic run_strings(input int unsigned count);
      int unsigned sent;
      int unsigned len;
      int unsigned nest;
      int unsigned pick;
      int unsigned i;
      logic [SYM_W-1:0] sym;
      bit first;
      sent = 0;
      while (sent < count) begin
         len  = $urandom_range(40, 4);
         nest = 0;
         for (i = 0; i < len; i++) begin
            first = (i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(49) == 0);
            if (first) nest = 0;
            pick = $urandom_range(99);
            if (pick < 35)      sym = SYM_F;
            else if (pick < 45) sym = SYM_G;
            else if (pick < 60) sym = SYM_PLUS;
            else if (pick < 75) sym = SYM_MINUS;
            else if (pick < 85) begin
               sym  = SYM_PUSH;
               nest = nest + 1;
            end else if (pick < 95) begin
               sym = (nest > 0 || $urandom_range(4) == 0) ? SYM_POP : SYM_F;
               if (nest > 0) nest = nest - 1;
            end else begin
               sym = SYM_W'($urandom_range(255));
            end
            send_symbol(sym, first, random_jitter());
            sent++;
         end
      end
   endtask

   initial begin
      ledger = new;
      ledger.restore_defaults();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      repeat (QUIET_CYCLES) @(posedge clock);

      // reset settings, sender 35 / receiver 50 idle
      run_directed();
      drain();

      // registers above range, longest step, coordinates at the rails
      load_settings(24'd131071, 24'd131071, 24'd1048575, 24'h7FFFFF, 24'h800000, 24'd1);
      send_symbol(SYM_PLUS,  1'b1, 16'h7FFF);
      send_symbol(SYM_F,     1'b0, '0);
      send_symbol(SYM_MINUS, 1'b0, 16'h8000);
      send_symbol(SYM_F,     1'b0, '0);
      send_symbol(SYM_PLUS,  1'b0, 16'd23040);
      send_symbol(SYM_MINUS, 1'b0, -16'sd23040);
      send_symbol(SYM_F,     1'b0, '0);
      run_deep_nest();
      run_strings(40);
      drain();

      // zero turn, zero heading, no movement
      load_settings(24'd0, 24'd0, 24'd0, 24'h800000, 24'h7FFFFF, 24'd0);
      run_strings(30);
      drain();

      // sender 50 / receiver 35 idle; hold the receiver off while items pile up
      send_idle_pct = 50;
      recv_idle_pct = 35;
      load_settings(24'd92159, 24'd92159, CSR_W'($urandom_range(4095)),
                    CSR_W'($urandom), CSR_W'($urandom), 24'd1);
      hold_rsp <= 1'b1;
      run_strings(50);
      drain();

      load_settings(CSR_W'($urandom_range(131071)), CSR_W'($urandom_range(131071)),
                    CSR_W'($urandom_range(1048575)), CSR_W'($urandom), CSR_W'($urandom),
                    CSR_W'($urandom_range(1)));
      run_strings(50);
      drain();

      // no idling on either side
      send_idle_pct = 0;
      recv_idle_pct = 0;
      load_settings(24'd23040, 24'd46080, 24'd1048575, 24'h7FFF00, 24'h800100, 24'd1);
      run_strings(50);
      drain();

      load_settings(CSR_W'($urandom_range(131071)), CSR_W'($urandom_range(131071)),
                    CSR_W'($urandom_range(65535)), CSR_W'($urandom), CSR_W'($urandom),
                    CSR_W'($urandom_range(1)));
      run_strings(50);
      drain();

      if (ledger.fault_count == 0)
         $display("** bracketed_turtle_interpreter_unit: PASSED **");
      else
         $display("** bracketed_turtle_interpreter_unit: FAILED **");
      $finish;
   end

endmodule
